FILE: sv/trm_pkg.sv
// Shared types, codes and sizes for the register machine execute block.
`timescale 1ns / 1ps

package trm_pkg;

  localparam int NUM_REGS  = 5;
  localparam int MEM_WORDS = 64;
  localparam int WORD_W    = 32;
  localparam int PC_W      = 16;
  localparam int REG_AW    = $clog2(NUM_REGS);
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  localparam logic [2:0] CMD_MOV = 3'd0;
  localparam logic [2:0] CMD_ADD = 3'd1;
  localparam logic [2:0] CMD_SUB = 3'd2;
  localparam logic [2:0] CMD_JMP = 3'd3;
  localparam logic [2:0] CMD_JPN = 3'd4;
  localparam logic [2:0] CMD_PRN = 3'd5;
  localparam logic [2:0] CMD_HLT = 3'd6;

  localparam logic FIRST_REG  = 1'b0;
  localparam logic FIRST_ADDR = 1'b1;

  localparam logic [1:0] KIND_REG   = 2'd0;
  localparam logic [1:0] KIND_ADDR  = 2'd1;
  localparam logic [1:0] KIND_CONST = 2'd2;

  localparam logic [PC_W-1:0] PC_RESET = PC_W'(1);

  typedef struct packed {
    logic [2:0]               cmd;
    logic                     first_kind;
    logic [2:0]               first_reg;
    logic [5:0]               first_addr;
    logic [1:0]               second_kind;
    logic [2:0]               second_reg;
    logic [5:0]               second_addr;
    logic signed [WORD_W-1:0] second_const;
    logic [PC_W-1:0]          jump_target;
  } trm_in_t;

  typedef struct packed {
    logic [PC_W-1:0]          next_pc;
    logic                     print_valid;
    logic signed [WORD_W-1:0] print_value;
    logic                     halted;
    logic                     bad_instruction;
  } trm_out_t;

  typedef struct packed {
    logic              reg_we;
    logic [REG_AW-1:0] reg_addr;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_addr;
    logic [WORD_W-1:0] data;
  } trm_wr_t;

endpackage

FILE: sv/trm_in_if.sv
// Instruction channel interface: valid, ready and one decoded instruction.
`timescale 1ns / 1ps

interface trm_in_if;
  import trm_pkg::*;

  logic    valid;
  logic    ready;
  trm_in_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: sv/trm_out_if.sv
// Result channel interface: valid, ready and one execution result.
`timescale 1ns / 1ps

interface trm_out_if;
  import trm_pkg::*;

  logic     valid;
  logic     ready;
  trm_out_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: sv/tiny_register_machine_execute.sv
// An accepted instruction is registered into the execute stage, its result into the output.
// Throughput: one instruction per cycle unless the result channel stalls; register file and
// data memory reads are registered, and the previous write is forwarded to the next one.
// Reset: PC becomes 1; per-entry valid bits for the register file and data memory clear,
// so every entry reads as zero until written. No clearing pass is needed.
`timescale 1ns / 1ps

module tiny_register_machine_execute (
  input logic      clk,
  input logic      rst,
  trm_in_if.sink   instr,
  trm_out_if.source result
);
  import trm_pkg::*;

  logic              s1_valid;
  trm_in_t           s1_instr;
  logic              accept;
  logic              advance;
  logic [PC_W-1:0]   pc;

  logic [NUM_REGS-1:0]  reg_vld;
  logic [MEM_WORDS-1:0] mem_vld;

  logic [WORD_W-1:0] reg_rd_a;
  logic [WORD_W-1:0] reg_rd_b;
  logic [WORD_W-1:0] mem_rd_a;
  logic [WORD_W-1:0] mem_rd_b;

  logic [REG_AW-1:0] ra_idx;
  logic [REG_AW-1:0] rb_idx;
  logic [MEM_AW-1:0] ma_idx;
  logic [MEM_AW-1:0] mb_idx;

  logic [WORD_W-1:0] reg_a;
  logic [WORD_W-1:0] reg_b;
  logic [WORD_W-1:0] mem_a;
  logic [WORD_W-1:0] mem_b;

  trm_wr_t           wr;
  trm_wr_t           fwd;
  trm_out_t          res;

  logic              out_valid;
  trm_out_t          out_data;

  assign advance     = s1_valid && (!out_valid || result.ready);
  assign instr.ready = !s1_valid || advance;
  assign accept      = instr.valid && instr.ready;

  trm_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_reg_ram (
    .clk     (clk),
    .we      (advance && wr.reg_we),
    .waddr   (wr.reg_addr),
    .wdata   (wr.data),
    .re      (accept),
    .raddr_a (REG_AW'(instr.data.first_reg)),
    .raddr_b (REG_AW'(instr.data.second_reg)),
    .rdata_a (reg_rd_a),
    .rdata_b (reg_rd_b)
  );

  trm_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_mem_ram (
    .clk     (clk),
    .we      (advance && wr.mem_we),
    .waddr   (wr.mem_addr),
    .wdata   (wr.data),
    .re      (accept),
    .raddr_a (MEM_AW'(instr.data.first_addr)),
    .raddr_b (MEM_AW'(instr.data.second_addr)),
    .rdata_a (mem_rd_a),
    .rdata_b (mem_rd_b)
  );

  assign ra_idx = REG_AW'(s1_instr.first_reg);
  assign rb_idx = REG_AW'(s1_instr.second_reg);
  assign ma_idx = MEM_AW'(s1_instr.first_addr);
  assign mb_idx = MEM_AW'(s1_instr.second_addr);

  always_comb begin
    if (fwd.reg_we && fwd.reg_addr == ra_idx) begin
      reg_a = fwd.data;
    end else begin
      reg_a = reg_vld[ra_idx] ? reg_rd_a : '0;
    end
    if (fwd.reg_we && fwd.reg_addr == rb_idx) begin
      reg_b = fwd.data;
    end else begin
      reg_b = reg_vld[rb_idx] ? reg_rd_b : '0;
    end
    if (fwd.mem_we && fwd.mem_addr == ma_idx) begin
      mem_a = fwd.data;
    end else begin
      mem_a = mem_vld[ma_idx] ? mem_rd_a : '0;
    end
    if (fwd.mem_we && fwd.mem_addr == mb_idx) begin
      mem_b = fwd.data;
    end else begin
      mem_b = mem_vld[mb_idx] ? mem_rd_b : '0;
    end
  end

  trm_exec u_exec (
    .instr (s1_instr),
    .pc    (pc),
    .reg_a (reg_a),
    .reg_b (reg_b),
    .mem_a (mem_a),
    .mem_b (mem_b),
    .wr    (wr),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      pc         <= PC_RESET;
      reg_vld    <= '0;
      mem_vld    <= '0;
      fwd.reg_we <= 1'b0;
      fwd.mem_we <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        pc        <= res.next_pc;
        fwd       <= wr;
        if (wr.reg_we) begin
          reg_vld[wr.reg_addr] <= 1'b1;
        end
        if (wr.mem_we) begin
          mem_vld[wr.mem_addr] <= 1'b1;
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_instr <= instr.data;
    end
    if (advance) begin
      out_data <= res;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

`ifndef ASSERT_OFF
  a_pc_matches_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.next_pc == pc)
    else $error("Program counter differs from the pending transaction's next PC.");

  a_single_write: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !(wr.reg_we && wr.mem_we))
    else $error("One instruction writes both the register file and the memory.");

  a_bad_has_no_effect: assert property (@(posedge clk) disable iff (rst)
    s1_valid && res.bad_instruction |-> !wr.reg_we && !wr.mem_we && res.next_pc == pc)
    else $error("Unsupported instruction changes machine state.");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid && out_data.next_pc == pc)
    else $error("Executed instruction did not reach the output register.");
`endif

endmodule

FILE: sv/trm_ram.sv
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module trm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: sv/trm_exec.sv
// Execute logic: decodes one instruction, computes its write-back and its result.
`timescale 1ns / 1ps

module trm_exec (
  input  trm_pkg::trm_in_t                 instr,
  input  logic [trm_pkg::PC_W-1:0]         pc,
  input  logic [trm_pkg::WORD_W-1:0]       reg_a,
  input  logic [trm_pkg::WORD_W-1:0]       reg_b,
  input  logic [trm_pkg::WORD_W-1:0]       mem_a,
  input  logic [trm_pkg::WORD_W-1:0]       mem_b,
  output trm_pkg::trm_wr_t                 wr,
  output trm_pkg::trm_out_t                res
);
  import trm_pkg::*;

  logic              fr_ok;
  logic              sr_ok;
  logic              fa_ok;
  logic              sa_ok;
  logic              sec_ok;
  logic [WORD_W-1:0] sec_val;
  logic              bad;
  logic              take;
  logic [PC_W-1:0]   npc;

  assign fr_ok = 32'(instr.first_reg) < NUM_REGS;
  assign sr_ok = 32'(instr.second_reg) < NUM_REGS;
  assign fa_ok = 32'(instr.first_addr) < MEM_WORDS;
  assign sa_ok = 32'(instr.second_addr) < MEM_WORDS;

  always_comb begin
    case (instr.second_kind)
      KIND_REG: begin
        sec_ok  = sr_ok;
        sec_val = reg_b;
      end
      KIND_ADDR: begin
        sec_ok  = sa_ok;
        sec_val = mem_b;
      end
      KIND_CONST: begin
        sec_ok  = 1'b1;
        sec_val = instr.second_const;
      end
      default: begin
        sec_ok  = 1'b0;
        sec_val = '0;
      end
    endcase
  end

  always_comb begin
    wr          = '0;
    bad         = 1'b0;
    take        = 1'b0;
    npc         = pc + PC_W'(1);
    res         = '0;
    unique case (instr.cmd)
      CMD_MOV: begin
        if (instr.first_kind == FIRST_REG) begin
          if (!fr_ok) begin
            bad = 1'b1;
          end else if (instr.second_kind == KIND_REG && sr_ok) begin
            wr.reg_we   = 1'b1;
            wr.reg_addr = REG_AW'(instr.second_reg);
            wr.data     = reg_a;
          end else if (instr.second_kind == KIND_ADDR && sa_ok) begin
            wr.mem_we   = 1'b1;
            wr.mem_addr = MEM_AW'(instr.second_addr);
            wr.data     = reg_a;
          end else if (instr.second_kind == KIND_CONST) begin
            wr.reg_we   = 1'b1;
            wr.reg_addr = REG_AW'(instr.first_reg);
            wr.data     = instr.second_const;
          end else begin
            bad = 1'b1;
          end
        end else begin
          if (!fa_ok) begin
            bad = 1'b1;
          end else if (instr.second_kind == KIND_REG && sr_ok) begin
            wr.reg_we   = 1'b1;
            wr.reg_addr = REG_AW'(instr.second_reg);
            wr.data     = mem_a;
          end else if (instr.second_kind == KIND_CONST) begin
            wr.mem_we   = 1'b1;
            wr.mem_addr = MEM_AW'(instr.first_addr);
            wr.data     = instr.second_const;
          end else begin
            bad = 1'b1;
          end
        end
      end
      CMD_ADD, CMD_SUB: begin
        if (instr.first_kind != FIRST_REG || !fr_ok || !sec_ok) begin
          bad = 1'b1;
        end else begin
          wr.reg_we   = 1'b1;
          wr.reg_addr = REG_AW'(instr.first_reg);
          wr.data     = (instr.cmd == CMD_ADD) ? reg_a + sec_val : reg_a - sec_val;
        end
      end
      CMD_JMP, CMD_JPN: begin
        if (instr.second_kind == KIND_REG && sr_ok) begin
          take = (reg_b == '0) || (instr.cmd == CMD_JPN && reg_b[WORD_W-1]);
          if (take) begin
            npc = instr.jump_target;
          end
        end else if (instr.second_kind == KIND_CONST) begin
          npc = instr.jump_target;
        end else begin
          bad = 1'b1;
        end
      end
      CMD_PRN: begin
        if (!sec_ok) begin
          bad = 1'b1;
        end else begin
          res.print_valid = 1'b1;
          res.print_value = sec_val;
        end
      end
      CMD_HLT: begin
        res.halted = 1'b1;
        npc        = pc;
      end
      default: begin
        bad = 1'b1;
      end
    endcase

    if (bad) begin
      wr              = '0;
      npc             = pc;
      res.print_valid = 1'b0;
      res.print_value = '0;
      res.halted      = 1'b0;
    end
    res.next_pc         = npc;
    res.bad_instruction = bad;
  end

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the register machine execute block.
`timescale 1ns / 1ps

module tb_top;
  import trm_pkg::*;

  localparam logic [2:0] CMD_UNUSED  = 3'd7;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         RANDOM_ITEMS = 525;

  logic clk;
  logic rst;

  trm_in_if  instr_if();
  trm_out_if result_if();

  tiny_register_machine_execute DUT (
    .clk(clk),
    .rst(rst),
    .instr(instr_if),
    .result(result_if)
  );

  logic [WORD_W-1:0] gpr [NUM_REGS];
  logic [WORD_W-1:0] data_words [MEM_WORDS];
  logic [PC_W-1:0]   model_pc;

  trm_in_t  pending_instrs[$];
  trm_out_t expected_results[$];

  int   mismatch_count = 0;
  int   accepted_count = 0;
  int   cycle_count = 0;
  logic instr_taken = 1'b0;
  logic rx_holding = 1'b0;

  int          burst_left = 0;
  int          gap_left = 0;
  int          hold_left = 0;
  logic        long_hold_done = 1'b0;
  logic [15:0] stall_pattern = '1;
  int          pattern_age = 0;
  logic [3:0]  pattern_idx = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic read_operand(input trm_in_t ins, output logic [WORD_W-1:0] v);
    v = '0;
    read_operand = 1'b1;
    case (ins.second_kind)
      KIND_REG: begin
        if (ins.second_reg < NUM_REGS) v = gpr[ins.second_reg];
        else read_operand = 1'b0;
      end
      KIND_ADDR: begin
        if (ins.second_addr < MEM_WORDS) v = data_words[ins.second_addr];
        else read_operand = 1'b0;
      end
      KIND_CONST: v = ins.second_const;
      default: read_operand = 1'b0;
    endcase
  endfunction

  function automatic trm_out_t execute_instr(input trm_in_t ins);
    trm_out_t          res;
    logic              bad;
    logic              take;
    logic [PC_W-1:0]   npc;
    logic [WORD_W-1:0] opnd;
    logic [WORD_W-1:0] x;
    res = '0;
    bad = 1'b0;
    npc = model_pc + 1'b1;
    case (ins.cmd)
      CMD_MOV: begin
        if (ins.first_kind == FIRST_REG) begin
          if (ins.first_reg >= NUM_REGS) bad = 1'b1;
          else if (ins.second_kind == KIND_REG && ins.second_reg < NUM_REGS)
            gpr[ins.second_reg] = gpr[ins.first_reg];
          else if (ins.second_kind == KIND_ADDR && ins.second_addr < MEM_WORDS)
            data_words[ins.second_addr] = gpr[ins.first_reg];
          else if (ins.second_kind == KIND_CONST) gpr[ins.first_reg] = ins.second_const;
          else bad = 1'b1;
        end else begin
          if (ins.first_addr >= MEM_WORDS) bad = 1'b1;
          else if (ins.second_kind == KIND_REG && ins.second_reg < NUM_REGS)
            gpr[ins.second_reg] = data_words[ins.first_addr];
          else if (ins.second_kind == KIND_CONST) data_words[ins.first_addr] = ins.second_const;
          else bad = 1'b1;
        end
      end
      CMD_ADD, CMD_SUB: begin
        if (ins.first_kind != FIRST_REG || ins.first_reg >= NUM_REGS || !read_operand(ins, opnd))
          bad = 1'b1;
        else if (ins.cmd == CMD_ADD) gpr[ins.first_reg] = gpr[ins.first_reg] + opnd;
        else gpr[ins.first_reg] = gpr[ins.first_reg] - opnd;
      end
      CMD_JMP, CMD_JPN: begin
        if (ins.second_kind == KIND_REG && ins.second_reg < NUM_REGS) begin
          x = gpr[ins.second_reg];
          take = (ins.cmd == CMD_JMP) ? (x == '0) : (x == '0 || x[WORD_W-1]);
          if (take) npc = ins.jump_target;
        end else if (ins.second_kind == KIND_CONST) begin
          npc = ins.jump_target;
        end else begin
          bad = 1'b1;
        end
      end
      CMD_PRN: begin
        if (!read_operand(ins, opnd)) bad = 1'b1;
        else begin
          res.print_valid = 1'b1;
          res.print_value = opnd;
        end
      end
      CMD_HLT: begin
        res.halted = 1'b1;
        npc = model_pc;
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      npc = model_pc;
      res.print_valid = 1'b0;
      res.print_value = '0;
      res.halted = 1'b0;
    end
    res.bad_instruction = bad;
    res.next_pc = npc;
    model_pc = npc;
    return res;
  endfunction

  function automatic trm_in_t make_instr(
    input logic [2:0] cmd, input logic fk, input logic [2:0] fr, input logic [5:0] fa,
    input logic [1:0] sk, input logic [2:0] sr, input logic [5:0] sa,
    input logic [WORD_W-1:0] sc, input logic [PC_W-1:0] jt);
    trm_in_t ins;
    ins.cmd = cmd;
    ins.first_kind = fk;
    ins.first_reg = fr;
    ins.first_addr = fa;
    ins.second_kind = sk;
    ins.second_reg = sr;
    ins.second_addr = sa;
    ins.second_const = sc;
    ins.jump_target = jt;
    return ins;
  endfunction

  function automatic logic [2:0] random_reg();
    if ($urandom_range(0, 99) < 92) return 3'($urandom_range(0, NUM_REGS - 1));
    return 3'($urandom_range(NUM_REGS, 7));
  endfunction

  function automatic trm_in_t random_instr();
    trm_in_t ins;
    int      pick;
    ins = trm_in_t'({$urandom, $urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 24) ins.cmd = CMD_MOV;
    else if (pick < 42) ins.cmd = CMD_ADD;
    else if (pick < 56) ins.cmd = CMD_SUB;
    else if (pick < 66) ins.cmd = CMD_JMP;
    else if (pick < 76) ins.cmd = CMD_JPN;
    else if (pick < 92) ins.cmd = CMD_PRN;
    else if (pick < 97) ins.cmd = CMD_HLT;
    else ins.cmd = CMD_UNUSED;
    ins.first_kind = ($urandom_range(0, 99) < 80) ? FIRST_REG : FIRST_ADDR;
    ins.first_reg = random_reg();
    ins.second_reg = random_reg();
    if ($urandom_range(0, 99) < 75) begin
      ins.first_addr = 6'($urandom_range(0, 7));
      ins.second_addr = 6'($urandom_range(0, 7));
    end
    ins.second_kind = ($urandom_range(0, 99) < 3) ? KIND_UNUSED : 2'($urandom_range(0, 2));
    case ($urandom_range(0, 4))
      0: ins.second_const = '0;
      1: ins.second_const = WORD_W'($signed($urandom_range(0, 8)) - 4);
      2: begin
        case ($urandom_range(0, 2))
          0: ins.second_const = {1'b1, {(WORD_W-1){1'b0}}};
          1: ins.second_const = {1'b0, {(WORD_W-1){1'b1}}};
          default: ins.second_const = '1;
        endcase
      end
      default: ins.second_const = $urandom;
    endcase
    return ins;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("tb_top: %s at %0t: expected %h, got %h", what, $time, want, got);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_instrs.size() != 0 || instr_if.valid || expected_results.size() != 0);
  endtask

  // Instruction driver: bursts of transactions separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      instr_if.valid <= 1'b0;
    end else if (!instr_if.valid || instr_taken) begin
      if (gap_left > 0 && !rx_holding) begin
        instr_if.valid <= 1'b0;
        gap_left--;
      end else if (pending_instrs.size() > 0) begin
        instr_if.data <= pending_instrs.pop_front();
        instr_if.valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        instr_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: stalls on a changing pattern, with one long hold-off.
  always @(negedge clk) begin
    if (!long_hold_done && accepted_count >= 150) begin
      long_hold_done = 1'b1;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_if.ready <= 1'b0;
      rx_holding <= 1'b1;
    end else begin
      if (pattern_age == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pattern = '1;
          1: stall_pattern = 16'($urandom);
          2: stall_pattern = 16'($urandom | $urandom);
          default: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
        endcase
        pattern_age = $urandom_range(16, 80);
      end else begin
        pattern_age--;
      end
      result_if.ready <= stall_pattern[pattern_idx];
      pattern_idx++;
      rx_holding <= 1'b0;
    end
  end

  // Monitor: predicts on each accepted instruction and checks each accepted result.
  always @(posedge clk) begin
    trm_out_t want;
    trm_out_t got;
    if (rst) begin
      instr_taken <= 1'b0;
    end else begin
      instr_taken <= instr_if.valid && instr_if.ready;
      if (result_if.valid && result_if.ready) begin
        got = result_if.data;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no instruction pending", '0, 32'(got));
        end else begin
          want = expected_results.pop_front();
          if (got.next_pc !== want.next_pc)
            report_mismatch("next_pc", 32'(want.next_pc), 32'(got.next_pc));
          if (got.print_valid !== want.print_valid)
            report_mismatch("print_valid", 32'(want.print_valid), 32'(got.print_valid));
          if (got.print_value !== want.print_value)
            report_mismatch("print_value", want.print_value, got.print_value);
          if (got.halted !== want.halted)
            report_mismatch("halted", 32'(want.halted), 32'(got.halted));
          if (got.bad_instruction !== want.bad_instruction)
            report_mismatch("bad_instruction", 32'(want.bad_instruction),
                            32'(got.bad_instruction));
        end
      end
      if (instr_if.valid && instr_if.ready) begin
        expected_results.push_back(execute_instr(instr_if.data));
        accepted_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    instr_if.valid = 1'b0;
    instr_if.data = '0;
    result_if.ready = 1'b0;
    foreach (gpr[i]) gpr[i] = '0;
    foreach (data_words[i]) data_words[i] = '0;
    model_pc = PC_RESET;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: value extremes, every operation and several rejected combinations.
    pending_instrs.push_back(make_instr(CMD_PRN, FIRST_REG, 0, 0, KIND_REG, 0, 0, 0, 0));
    pending_instrs.push_back(make_instr(CMD_PRN, FIRST_REG, 0, 0, KIND_ADDR, 0, 63, 0, 0));
    pending_instrs.push_back(make_instr(CMD_MOV, FIRST_REG, 0, 0, KIND_CONST, 0, 0,
                                        32'h7FFF_FFFF, 0));
    pending_instrs.push_back(make_instr(CMD_ADD, FIRST_REG, 0, 0, KIND_CONST, 0, 0, 1, 0));
    pending_instrs.push_back(make_instr(CMD_PRN, FIRST_REG, 0, 0, KIND_REG, 0, 0, 0, 0));
    pending_instrs.push_back(make_instr(CMD_MOV, FIRST_REG, 0, 0, KIND_REG, 4, 0, 0, 0));
    pending_instrs.push_back(make_instr(CMD_MOV, FIRST_REG, 4, 0, KIND_ADDR, 0, 63, 0, 0));
    pending_instrs.push_back(make_instr(CMD_MOV, FIRST_ADDR, 0, 63, KIND_REG, 1, 0, 0, 0));
    pending_instrs.push_back(make_instr(CMD_MOV, FIRST_ADDR, 0, 0, KIND_CONST, 0, 0, '1, 0));
    pending_instrs.push_back(make_instr(CMD_SUB, FIRST_REG, 1, 0, KIND_ADDR, 0, 0, 0, 0));
    pending_instrs.push_back(make_instr(CMD_ADD, FIRST_REG, 2, 0, KIND_REG, 1, 0, 0, 0));
    pending_instrs.push_back(make_instr(CMD_PRN, FIRST_REG, 0, 0, KIND_CONST, 0, 0,
                                        32'h8000_0000, 0));
    pending_instrs.push_back(make_instr(CMD_JMP, FIRST_REG, 0, 0, KIND_REG, 3, 0, 0, 16'hFFFF));
    pending_instrs.push_back(make_instr(CMD_JMP, FIRST_REG, 0, 0, KIND_REG, 0, 0, 0, 16'h0BAD));
    pending_instrs.push_back(make_instr(CMD_JPN, FIRST_REG, 0, 0, KIND_REG, 4, 0, 0, 16'h1234));
    pending_instrs.push_back(make_instr(CMD_JPN, FIRST_REG, 0, 0, KIND_REG, 1, 0, 0, 16'h4321));
    pending_instrs.push_back(make_instr(CMD_JMP, FIRST_REG, 0, 0, KIND_CONST, 0, 0, 5, 16'hFFFF));
    pending_instrs.push_back(make_instr(CMD_MOV, FIRST_REG, 3, 0, KIND_CONST, 0, 0, 0, 0));
    pending_instrs.push_back(make_instr(CMD_HLT, FIRST_REG, 0, 0, KIND_REG, 0, 0, 0, 0));
    pending_instrs.push_back(make_instr(CMD_MOV, FIRST_ADDR, 0, 1, KIND_ADDR, 0, 2, 0, 0));
    pending_instrs.push_back(make_instr(CMD_ADD, FIRST_ADDR, 0, 1, KIND_CONST, 0, 0, 1, 0));
    pending_instrs.push_back(make_instr(CMD_JPN, FIRST_REG, 0, 0, KIND_ADDR, 0, 1, 0, 16'h0077));
    pending_instrs.push_back(make_instr(CMD_PRN, FIRST_REG, 0, 0, KIND_UNUSED, 0, 0, 0, 0));
    pending_instrs.push_back(make_instr(CMD_UNUSED, FIRST_REG, 0, 0, KIND_REG, 0, 0, 0, 0));
    pending_instrs.push_back(make_instr(CMD_MOV, FIRST_REG, 7, 0, KIND_CONST, 0, 0, 9, 0));
    pending_instrs.push_back(make_instr(CMD_JMP, FIRST_REG, 0, 0, KIND_REG, 5, 0, 0, 16'h0042));
    wait_drained();

    repeat (RANDOM_ITEMS / 2) pending_instrs.push_back(random_instr());
    wait_drained();
    repeat (RANDOM_ITEMS - RANDOM_ITEMS / 2) pending_instrs.push_back(random_instr());
    wait_drained();

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results still expected", '0, expected_results.size());
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
